// ===== design/srg_pkg.sv =====
`default_nettype none
package srg_pkg;

  localparam int LEVEL_W    = 32;
  localparam int POS_W      = 24;
  localparam int OP_W       = 34;
  localparam int PROD_W     = 52;
  localparam int QUO_W      = 48;
  localparam int DIVD_W     = 32;
  localparam int STEP_W     = 6;
  localparam int CURVE_FRAC = 30;
  localparam int RATIO_FRAC = 16;

  localparam longint Q_ONE_L  = 64'sd1 << CURVE_FRAC;
  localparam longint Q_HALF_L = 64'sd1 << (CURVE_FRAC - 1);
  localparam longint KP1_L    = (64'sd629 * Q_ONE_L + 64'sd896) / 64'sd1792;
  localparam longint KP2_L    = (64'sd1163 * Q_ONE_L + 64'sd896) / 64'sd1792;

  localparam logic signed [OP_W-1:0] Q_ONE   = OP_W'(Q_ONE_L);
  localparam logic signed [OP_W-1:0] Q_HALF  = OP_W'(Q_HALF_L);
  localparam logic signed [OP_W-1:0] K_POLY1 = OP_W'(KP1_L);
  localparam logic signed [OP_W-1:0] K_POLY2 = OP_W'(KP2_L);
  localparam logic signed [OP_W-1:0] K_SIN0  = OP_W'(64'sd1686004129);
  localparam logic signed [OP_W-1:0] K_SIN1  = OP_W'(-64'sd2757668350);
  localparam logic signed [OP_W-1:0] K_SIN2  = OP_W'(64'sd1234476520);

  localparam logic signed [LEVEL_W-1:0] LVL_MAX = {1'b0, {(LEVEL_W-1){1'b1}}};
  localparam logic signed [LEVEL_W-1:0] LVL_MIN = {1'b1, {(LEVEL_W-1){1'b0}}};

  localparam logic [2:0] SHP_HOLD = 3'd0;
  localparam logic [2:0] SHP_LIN  = 3'd1;
  localparam logic [2:0] SHP_SIN  = 3'd2;
  localparam logic [2:0] SHP_EXP  = 3'd3;
  localparam logic [2:0] SHP_LOG  = 3'd4;
  localparam logic [2:0] SHP_XPE  = 3'd5;
  localparam logic [2:0] SHP_LGE  = 3'd6;

  localparam logic [STEP_W-1:0] STEPS_X = STEP_W'(CURVE_FRAC);
  localparam logic [STEP_W-1:0] STEPS_R = STEP_W'(QUO_W);

  typedef struct packed {
    logic               start;
    logic [DIVD_W-1:0]  rem_init;
    logic [QUO_W-1:0]   dividend;
    logic [STEP_W-1:0]  steps;
    logic [DIVD_W-1:0]  divisor;
  } div_req_t;

  function automatic logic signed [LEVEL_W-1:0] sat_lvl(input logic signed [PROD_W:0] v);
    logic signed [LEVEL_W-1:0] r;
    if (v > (PROD_W+1)'(LVL_MAX)) r = LVL_MAX;
    else if (v < (PROD_W+1)'(LVL_MIN)) r = LVL_MIN;
    else r = v[LEVEL_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/srg_mul.sv =====
`default_nettype none
module srg_mul (
  input  wire                                    clk,
  input  wire logic signed [srg_pkg::OP_W-1:0]   a,
  input  wire logic signed [srg_pkg::OP_W-1:0]   b,
  input  wire logic                              sh16,
  output logic signed [srg_pkg::PROD_W-1:0]      prod
);
  import srg_pkg::*;

  localparam logic signed [2*OP_W-1:0] RND16 = (2*OP_W)'(64'sd1 << (RATIO_FRAC - 1));
  localparam logic signed [2*OP_W-1:0] RND30 = (2*OP_W)'(64'sd1 << (CURVE_FRAC - 1));

  logic signed [2*OP_W-1:0] full;
  logic signed [2*OP_W-1:0] rnd;
  logic signed [2*OP_W-1:0] shd;

  // rounded to nearest, ties toward plus infinity
  always_comb begin
    full = a * b;
    rnd  = full + (sh16 ? RND16 : RND30);
    shd  = sh16 ? (rnd >>> RATIO_FRAC) : (rnd >>> CURVE_FRAC);
  end

  always_ff @(posedge clk) begin
    prod <= shd[PROD_W-1:0];
  end
endmodule
`default_nettype wire

// ===== design/srg_div.sv =====
`default_nettype none
module srg_div (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire srg_pkg::div_req_t              req,
  output logic [srg_pkg::QUO_W-1:0]           quo,
  output logic                                done
);
  import srg_pkg::*;

  logic [DIVD_W-1:0] rem;
  logic [QUO_W-1:0]  dvd;
  logic [DIVD_W-1:0] dvs;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic [DIVD_W:0]   trial;
  logic              ge;
  logic [DIVD_W:0]   diff;

  // restoring division, one quotient bit a cycle
  always_comb begin
    trial = {rem, dvd[QUO_W-1]};
    ge    = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // done pulses for one cycle after the last quotient bit
      done <= !req.start && busy && (cnt == STEP_W'(1));
      if (req.start) begin
        rem  <= req.rem_init;
        dvd  <= req.dividend;
        dvs  <= req.divisor;
        cnt  <= req.steps;
        quo  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[DIVD_W-1:0] : trial[DIVD_W-1:0];
        dvd <= {dvd[QUO_W-2:0], 1'b0};
        quo <= {quo[QUO_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/shaped_ramp_envelope_generator.sv =====
`default_nettype none
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tdata: tick multiplier and segment fields, tuser: mode
// m_*      out  m_tvalid/m_tready  tdata: sample_out, goal_pending
//
// one request at a time; a segment request returns nothing, a tick returns one sample
// tick with open curve: x = position/end_point comes from the bit-serial divider, then
//   the curve (none for hold) runs on the shared multiplier and a ratio goal scales the result;
//   a goal already at its end skips the divider and the curve
// a ratio conversion adds a division (plain to ratio, nonzero multiplier) or a multiply (ratio to plain)
// a tick without goal skips the divider; a segment runs the divider and the curve when an open goal
//   hands over its value; a sample waiting on m_* stalls the next request
// rst is synchronous, clears the envelope state and the output valid
module shaped_ramp_envelope_generator (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  // multiplier[31:0] update_mask[36:32] start_value[68:37] start_is_ratio[69]
  // goal_value[101:70] goal_is_ratio[102] shape[105:103] duration[129:106], zero pad
  input  wire  [135:0] s_tdata,
  // mode[0]
  input  wire  [0:0]   s_tuser,
  output logic         m_tvalid,
  input  wire          m_tready,
  // sample_out[31:0] goal_pending[32], zero pad
  output logic [39:0]  m_tdata
);
  import srg_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE, ST_NOGOAL, ST_CONV, ST_CONV_MW, ST_CONV_DW, ST_CHECK,
    ST_XD, ST_XW, ST_KIND,
    ST_SA, ST_SB, ST_SC, ST_SD, ST_SE, ST_SF, ST_SG,
    ST_EA, ST_EB, ST_EC, ST_ED, ST_EE, ST_EF, ST_EG, ST_EH,
    ST_FA, ST_FB, ST_POST, ST_RA, ST_RB, ST_TEND, ST_OUTP, ST_OUT, ST_SEG
  } state_t;

  state_t state;

  // envelope state
  logic signed [LEVEL_W-1:0] start_level;
  logic signed [LEVEL_W-1:0] goal_level;
  logic [POS_W-1:0]          position;
  logic [POS_W-1:0]          end_point;
  logic [2:0]                curve;
  logic                      goal_active;
  logic                      goal_ratio;
  logic                      start_ratio;
  logic                      time_set;

  // latched request
  logic                      is_seg;
  logic signed [LEVEL_W-1:0] mult;
  logic [4:0]                mask;
  logic signed [LEVEL_W-1:0] sv;
  logic                      sir;
  logic signed [LEVEL_W-1:0] gv;
  logic                      gir;
  logic [2:0]                shp;
  logic [POS_W-1:0]          dur;

  // work registers
  logic signed [OP_W-1:0]    x_r, t_r, p2, p3, acc, wv, fval, mval, diff;
  logic signed [LEVEL_W-1:0] base, cv, vreg;
  logic                      made, pend_r;

  // output register
  logic                      m_valid;
  logic signed [LEVEL_W-1:0] samp_o;
  logic                      pend_o;
  logic                      out_free;

  // shared units
  logic signed [OP_W-1:0]    mul_a, mul_b;
  logic                      mul_sh16;
  logic signed [PROD_W-1:0]  prod;
  div_req_t                  dreq;
  logic [QUO_W-1:0]          quo;
  logic                      ddone;

  logic [2:0]                kind_eff;
  logic                      need_div;
  logic [LEVEL_W-1:0]        ua, um;
  logic                      qneg;
  logic [QUO_W-1:0]          qlim, qcap;
  logic [POS_W-1:0]          pos_inc;
  logic                      pos_lt;

  srg_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .sh16(mul_sh16), .prod(prod));
  srg_div u_div (.clk(clk), .rst(rst), .req(dreq), .quo(quo), .done(ddone));

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = m_valid;
  assign m_tdata  = {7'b0, pend_o, samp_o};
  assign out_free = !m_valid || m_tready;
  assign pos_lt   = position < end_point;
  assign pos_inc  = position + POS_W'(1);

  // exp and log pick xpe or lge by ramp direction
  always_comb begin
    case (curve)
      SHP_EXP: kind_eff = (start_level > goal_level) ? SHP_XPE : SHP_LGE;
      SHP_LOG: kind_eff = (start_level < goal_level) ? SHP_XPE : SHP_LGE;
      default: kind_eff = curve;
    endcase
  end

  // ratio division operands, magnitudes
  always_comb begin
    ua       = unsigned'(start_level[LEVEL_W-1] ? -start_level : start_level);
    um       = unsigned'(mult[LEVEL_W-1] ? -mult : mult);
    qneg     = start_level[LEVEL_W-1] ^ mult[LEVEL_W-1];
    qlim     = qneg ? QUO_W'(64'd1 << (LEVEL_W-1)) : QUO_W'((64'd1 << (LEVEL_W-1)) - 64'd1);
    qcap     = (quo > qlim) ? qlim : quo;
    need_div = goal_ratio && !start_ratio && (mult != '0);
  end

  always_comb begin
    dreq = '0;
    if (state == ST_XD) begin
      dreq.start    = 1'b1;
      dreq.rem_init = DIVD_W'(position);
      dreq.steps    = STEPS_X;
      dreq.divisor  = DIVD_W'(end_point);
    end else if (state == ST_CONV && need_div) begin
      dreq.start    = 1'b1;
      dreq.dividend = {ua, {(QUO_W-LEVEL_W){1'b0}}};
      dreq.steps    = STEPS_R;
      dreq.divisor  = um;
    end
  end

  // multiplier operand select, the registered product lands in the next cycle
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_sh16 = 1'b0;
    case (state)
      ST_CONV, ST_NOGOAL: begin
        mul_a = OP_W'(start_level); mul_b = OP_W'(mult); mul_sh16 = 1'b1;
      end
      ST_TEND: begin
        mul_a = OP_W'(goal_level); mul_b = OP_W'(mult); mul_sh16 = 1'b1;
      end
      ST_RA: begin
        mul_a = OP_W'(cv); mul_b = OP_W'(mult); mul_sh16 = 1'b1;
      end
      ST_SA: begin mul_a = t_r;             mul_b = t_r;             end
      ST_SB: begin mul_a = prod[OP_W-1:0];  mul_b = K_SIN2;          end
      ST_SD: begin mul_a = p2;              mul_b = acc;             end
      ST_SF: begin mul_a = t_r;             mul_b = acc;             end
      ST_EA: begin mul_a = mval;            mul_b = mval;            end
      ST_EB: begin mul_a = prod[OP_W-1:0];  mul_b = mval;            end
      ST_EC: begin mul_a = p2;              mul_b = prod[OP_W-1:0];  end
      ST_ED: begin mul_a = mval;            mul_b = K_POLY1;         end
      ST_EE: begin mul_a = p2;              mul_b = K_POLY2;         end
      ST_EG: begin mul_a = acc;             mul_b = wv;              end
      ST_FA: begin mul_a = diff;            mul_b = fval;            end
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      start_level <= '0;
      goal_level  <= '0;
      position    <= '0;
      end_point   <= '0;
      curve       <= SHP_HOLD;
      goal_active <= 1'b0;
      goal_ratio  <= 1'b0;
      start_ratio <= 1'b0;
      time_set    <= 1'b0;
      m_valid     <= 1'b0;
    end else begin
      // the output state reloads the sample itself
      if (m_valid && m_tready && (state != ST_OUT)) m_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            is_seg <= s_tuser[0];
            mult   <= s_tdata[31:0];
            mask   <= s_tdata[36:32];
            sv     <= s_tdata[68:37];
            sir    <= s_tdata[69];
            gv     <= s_tdata[101:70];
            gir    <= s_tdata[102];
            shp    <= s_tdata[105:103];
            dur    <= s_tdata[129:106];
            if (s_tuser[0]) begin
              // an open goal hands its current value to the new one
              if (!s_tdata[32] && s_tdata[33] && goal_active && pos_lt) state <= ST_XD;
              else state <= ST_SEG;
            end else begin
              state <= goal_active ? ST_CONV : ST_NOGOAL;
            end
          end
        end
        ST_NOGOAL: begin
          pend_r <= 1'b0;
          if (pos_lt && (pos_inc < end_point)) begin
            position <= pos_inc;
          end else begin
            position <= '0;
            time_set <= 1'b0;
          end
          vreg  <= start_level;
          state <= start_ratio ? ST_OUTP : ST_OUT;
        end
        ST_CONV: begin
          if (goal_ratio && !start_ratio) begin
            if (mult == '0) begin
              // division by zero saturates by the sign of the start level
              if (start_level > 0) start_level <= LVL_MAX;
              else if (start_level < 0) start_level <= LVL_MIN;
              start_ratio <= 1'b1;
              state       <= ST_CHECK;
            end else begin
              state <= ST_CONV_DW;
            end
          end else if (!goal_ratio && start_ratio) begin
            state <= ST_CONV_MW;
          end else begin
            state <= ST_CHECK;
          end
        end
        ST_CONV_MW: begin
          start_level <= sat_lvl((PROD_W+1)'(prod));
          start_ratio <= 1'b0;
          state       <= ST_CHECK;
        end
        ST_CONV_DW: begin
          if (ddone) begin
            start_level <= qneg ? -signed'(qcap[LEVEL_W-1:0]) : signed'(qcap[LEVEL_W-1:0]);
            start_ratio <= 1'b1;
            state       <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          made  <= pos_lt;
          state <= pos_lt ? ST_XD : ST_TEND;
        end
        ST_XD: state <= ST_XW;
        ST_XW: begin
          if (ddone) begin
            x_r   <= OP_W'(quo[CURVE_FRAC-1:0]);
            state <= ST_KIND;
          end
        end
        ST_KIND: begin
          case (kind_eff)
            SHP_LIN: begin
              base <= start_level; diff <= OP_W'(goal_level) - OP_W'(start_level);
              fval <= x_r; state <= ST_FA;
            end
            SHP_SIN: begin
              base <= start_level; diff <= OP_W'(goal_level) - OP_W'(start_level);
              t_r <= x_r - Q_HALF; state <= ST_SA;
            end
            SHP_XPE: begin
              base <= goal_level; diff <= OP_W'(start_level) - OP_W'(goal_level);
              mval <= Q_ONE - x_r; state <= ST_EA;
            end
            SHP_LGE: begin
              base <= start_level; diff <= OP_W'(goal_level) - OP_W'(start_level);
              mval <= x_r; state <= ST_EA;
            end
            default: begin
              cv <= start_level; state <= ST_POST;
            end
          endcase
        end
        // sine polynomial around the midpoint
        ST_SA: state <= ST_SB;
        ST_SB: begin p2 <= prod[OP_W-1:0]; state <= ST_SC; end
        ST_SC: begin acc <= K_SIN1 + prod[OP_W-1:0]; state <= ST_SD; end
        ST_SD: state <= ST_SE;
        ST_SE: begin acc <= K_SIN0 + prod[OP_W-1:0]; state <= ST_SF; end
        ST_SF: state <= ST_SG;
        ST_SG: begin fval <= Q_HALF + prod[OP_W-1:0]; state <= ST_FA; end
        // envelope polynomial of m
        ST_EA: state <= ST_EB;
        ST_EB: begin p2 <= prod[OP_W-1:0]; state <= ST_EC; end
        ST_EC: begin p3 <= prod[OP_W-1:0]; state <= ST_ED; end
        ST_ED: begin acc <= prod[OP_W-1:0] - p2; state <= ST_EE; end
        ST_EE: begin wv <= prod[OP_W-1:0]; state <= ST_EF; end
        ST_EF: begin wv <= wv + prod[OP_W-1:0]; state <= ST_EG; end
        ST_EG: state <= ST_EH;
        ST_EH: begin fval <= p3 + prod[OP_W-1:0]; state <= ST_FA; end
        ST_FA: state <= ST_FB;
        ST_FB: begin
          cv    <= sat_lvl((PROD_W+1)'(base) + (PROD_W+1)'(prod));
          state <= ST_POST;
        end
        ST_POST: begin
          vreg <= cv;
          if (is_seg) state <= ST_SEG;
          else if (goal_ratio) state <= ST_RA;
          else state <= ST_TEND;
        end
        ST_RA: state <= ST_RB;
        ST_RB: begin
          vreg  <= sat_lvl((PROD_W+1)'(prod));
          state <= ST_TEND;
        end
        ST_TEND: begin
          if ((made ? pos_inc : position) >= end_point) begin
            // goal reached, its level is held from here on
            start_level <= goal_level;
            position    <= '0;
            goal_active <= 1'b0;
            goal_ratio  <= 1'b0;
            time_set    <= 1'b0;
            pend_r      <= 1'b0;
            if (!made) begin
              vreg  <= goal_level;
              state <= start_ratio ? ST_OUTP : ST_OUT;
            end else begin
              state <= ST_OUT;
            end
          end else begin
            position <= pos_inc;
            pend_r   <= 1'b1;
            state    <= ST_OUT;
          end
        end
        ST_OUTP: begin
          vreg  <= sat_lvl((PROD_W+1)'(prod));
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            m_valid <= 1'b1;
            samp_o  <= vreg;
            pend_o  <= pend_r;
            state   <= ST_IDLE;
          end
        end
        ST_SEG: begin
          if (mask[0]) begin
            start_level <= sv;
            start_ratio <= sir;
          end else if (goal_active && mask[1]) begin
            start_ratio <= goal_ratio;
            start_level <= pos_lt ? cv : goal_level;
          end
          if (mask[1]) begin
            goal_level  <= gv;
            position    <= '0;
            goal_active <= 1'b1;
            goal_ratio  <= gir;
          end
          if (mask[2]) curve <= shp;
          // a new duration wins over the shortened span unless a span is set and kept
          if ((!time_set || !mask[4]) && mask[3]) begin
            end_point <= dur;
            time_set  <= 1'b1;
          end else if (mask[1] && mask[4]) begin
            end_point <= (end_point > position) ? end_point - position : '0;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a ratio goal exists only while a goal is open
  a_ratio_goal: assert property (@(posedge clk) disable iff (rst)
    goal_ratio |-> goal_active)
    else $error("goal ratio set without an open goal");

  // an accepted request holds off the next one
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while busy");

  // reported pending flag matches the goal state when the sample is loaded
  a_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_free) |-> (pend_r == goal_active))
    else $error("pending flag disagrees with goal state");

endmodule
`default_nettype wire

// ===== bench/shaped_ramp_envelope_generator_test.sv =====
`timescale 1ns / 1ps
module shaped_ramp_envelope_generator_test;
  import srg_pkg::*;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_SEG  = 1'b1;
  localparam logic [4:0] UPD_START = 5'b00001;
  localparam logic [4:0] UPD_GOAL  = 5'b00010;
  localparam logic [4:0] UPD_CURVE = 5'b00100;
  localparam logic [4:0] UPD_DUR   = 5'b01000;
  localparam logic [4:0] UPD_KEEPT = 5'b10000;
  localparam logic [2:0] SHP_SPARE = 3'd7;
  localparam logic [23:0] DUR_MAX  = 24'hFFFFFF;
  localparam int RANDOM_ITEMS = 1130;

  typedef struct {
    logic              mode;
    logic signed [31:0] mult;
    logic [4:0]        mask;
    logic signed [31:0] sval;
    logic              sratio;
    logic signed [31:0] gval;
    logic              gratio;
    logic [2:0]        shape;
    logic [23:0]       dur;
  } ramp_req_t;

  typedef struct {
    logic [31:0] sample;
    logic        pending;
  } ramp_sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [135:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;

  shaped_ramp_envelope_generator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  ramp_req_t req_queue[$];
  ramp_req_t req_inflight[$];
  ramp_sample_t sample_queue[$];
  int n_issued = 0, n_accepted = 0, n_total = 0;
  int n_ticks = 0, n_segs = 0, n_samples = 0, n_errors = 0;
  int send_idle = 9, recv_idle = 66;

  // envelope state mirrored by the predictor
  longint lvl_start, lvl_goal;
  longint pos, end_pt;
  logic [2:0] env_curve;
  logic goal_open, goal_rat, start_rat, span_set;

  function automatic longint rnd_mul(longint a, longint b, int s);
    longint hi, lo;
    hi = a >>> s;
    lo = a - (hi <<< s);
    return hi * b + ((lo * b + (64'sd1 <<< (s - 1))) >>> s);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint ratio_quotient(longint a, longint m);
    longint q, ua, um, lim;
    logic neg;
    if (m == 0) return (a > 0) ? 64'sd2147483647 : (a < 0) ? -64'sd2147483648 : 64'sd0;
    ua = (a < 0) ? -a : a;
    um = (m < 0) ? -m : m;
    q = (ua <<< 16) / um;
    neg = (a < 0) != (m < 0);
    lim = neg ? 64'sd2147483648 : 64'sd2147483647;
    if (q > lim) q = lim;
    return neg ? -q : q;
  endfunction

  // capacitor-like polynomial on Q2.30
  function automatic longint cap_poly(longint m);
    longint p2, p3, p5, w;
    p2 = rnd_mul(m, m, CURVE_FRAC);
    p3 = rnd_mul(p2, m, CURVE_FRAC);
    p5 = rnd_mul(p2, p3, CURVE_FRAC);
    w = rnd_mul(m, KP1_L, CURVE_FRAC) + rnd_mul(p2, KP2_L, CURVE_FRAC);
    return p3 + rnd_mul(p5 - p2, w, CURVE_FRAC);
  endfunction

  function automatic longint sine_shape(longint x);
    longint t, t2, acc;
    t = x - Q_HALF_L;
    t2 = rnd_mul(t, t, CURVE_FRAC);
    acc = -64'sd2757668350 + rnd_mul(t2, 64'sd1234476520, CURVE_FRAC);
    acc = 64'sd1686004129 + rnd_mul(t2, acc, CURVE_FRAC);
    return Q_HALF_L + rnd_mul(t, acc, CURVE_FRAC);
  endfunction

  function automatic longint ramp_level(longint v0, longint vt, logic [2:0] kind,
                                        longint p, longint e);
    longint x, v;
    x = (p <<< CURVE_FRAC) / e;
    // exp and log pick the decay or its mirror by the ramp direction
    if (kind == SHP_EXP) kind = (v0 > vt) ? SHP_XPE : SHP_LGE;
    else if (kind == SHP_LOG) kind = (v0 < vt) ? SHP_XPE : SHP_LGE;
    case (kind)
      SHP_LIN: v = v0 + rnd_mul(vt - v0, x, CURVE_FRAC);
      SHP_SIN: v = v0 + rnd_mul(vt - v0, sine_shape(x), CURVE_FRAC);
      SHP_XPE: v = vt + rnd_mul(v0 - vt, cap_poly(Q_ONE_L - x), CURVE_FRAC);
      SHP_LGE: v = v0 + rnd_mul(vt - v0, cap_poly(x), CURVE_FRAC);
      default: v = v0;
    endcase
    return clamp32(v);
  endfunction

  // advance the mirrored envelope by one request, queue the sample a tick yields
  task automatic predict_ramp(input ramp_req_t r);
    longint v, m;
    logic made;
    ramp_sample_t e;
    m = r.mult;
    v = 0;
    if (r.mode == MODE_SEG) begin
      n_segs++;
      if (r.mask & UPD_START) begin
        lvl_start = r.sval;
        start_rat = r.sratio;
      end else if (goal_open && (r.mask & UPD_GOAL)) begin
        // open goal hands its current value over as the new start
        start_rat = goal_rat;
        lvl_start = (pos < end_pt) ? ramp_level(lvl_start, lvl_goal, env_curve, pos, end_pt)
                                   : lvl_goal;
      end
      if (r.mask & UPD_GOAL) begin
        lvl_goal = r.gval;
        if (r.mask & UPD_KEEPT) end_pt = (end_pt > pos) ? end_pt - pos : 0;
        pos = 0;
        goal_open = 1'b1;
        goal_rat = r.gratio;
      end
      if (r.mask & UPD_CURVE) env_curve = r.shape;
      if ((!span_set || !(r.mask & UPD_KEEPT)) && (r.mask & UPD_DUR)) begin
        end_pt = r.dur;
        span_set = 1'b1;
      end
      return;
    end
    n_ticks++;
    e.pending = 1'b0;
    if (!goal_open) begin
      // free-running position without a goal
      if (pos < end_pt) pos++;
      if (pos >= end_pt) begin
        pos = 0;
        span_set = 1'b0;
      end
      v = start_rat ? rnd_mul(lvl_start, m, 16) : lvl_start;
    end else begin
      made = 1'b0;
      if (goal_rat && !start_rat) begin
        lvl_start = ratio_quotient(lvl_start, m);
        start_rat = 1'b1;
      end else if (!goal_rat && start_rat) begin
        lvl_start = clamp32(rnd_mul(lvl_start, m, 16));
        start_rat = 1'b0;
      end
      if (pos < end_pt) begin
        v = ramp_level(lvl_start, lvl_goal, env_curve, pos, end_pt);
        if (goal_rat) v = rnd_mul(v, m, 16);
        pos++;
        made = 1'b1;
      end
      if (pos >= end_pt) begin
        lvl_start = lvl_goal;
        pos = 0;
        goal_open = 1'b0;
        goal_rat = 1'b0;
        span_set = 1'b0;
        if (!made) v = start_rat ? rnd_mul(lvl_start, m, 16) : lvl_start;
      end else begin
        e.pending = 1'b1;
      end
    end
    e.sample = 32'(clamp32(v));
    sample_queue.push_back(e);
  endtask

  task automatic add_tick(input logic [31:0] mult);
    ramp_req_t r;
    r = '{MODE_TICK, mult, 5'($urandom), $urandom, 1'($urandom), $urandom, 1'($urandom),
          3'($urandom), 24'($urandom)};
    req_queue.push_back(r);
  endtask

  task automatic add_seg(input logic [4:0] mask, input logic [31:0] sv, input logic sr,
                         input logic [31:0] gv, input logic gr, input logic [2:0] shp,
                         input logic [23:0] dur);
    ramp_req_t r;
    r = '{MODE_SEG, $urandom, mask, sv, sr, gv, gr, shp, dur};
    req_queue.push_back(r);
  endtask

  function automatic logic [31:0] pick_mult();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h0001_0000;
      2: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
      3: return 32'h0;
      default: return 32'($urandom_range(32'h0000_4000, 32'h0003_0000));
    endcase
  endfunction

  function automatic logic [31:0] pick_level();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
    endcase
  endfunction

  // stimulus
  initial begin
    int k, ticks;
    // directed: each curve in turn, the first ones between the extreme levels
    add_seg(UPD_START | UPD_GOAL | UPD_CURVE | UPD_DUR, 32'h8000_0000, 1'b0,
            32'h7FFF_FFFF, 1'b0, SHP_LIN, 24'd2);
    add_tick(32'h0001_0000); add_tick(32'h0001_0000); add_tick(32'h0001_0000);
    add_seg(UPD_GOAL | UPD_CURVE | UPD_DUR, 0, 1'b0, 32'h8000_0000, 1'b0, SHP_SIN, 24'd3);
    add_tick(0); add_tick(0);
    // new goal while the old one is open takes over its value
    add_seg(UPD_GOAL | UPD_CURVE, 0, 1'b0, 32'h0001_0000, 1'b1, SHP_EXP, 24'd0);
    add_tick(32'h0); add_tick(32'h7FFF_FFFF);
    add_seg(UPD_START | UPD_GOAL | UPD_CURVE | UPD_DUR, 32'h0002_0000, 1'b1,
            32'hFFFF_0000, 1'b0, SHP_LOG, 24'd4);
    add_tick(32'h8000_0000); add_tick(32'h0003_0000);
    add_seg(UPD_GOAL | UPD_KEEPT | UPD_CURVE, 0, 1'b0, 32'h0000_8000, 1'b0, SHP_XPE, 0);
    add_tick(32'h0001_0000);
    add_seg(UPD_GOAL | UPD_CURVE | UPD_DUR, 0, 1'b0, 32'h7FFF_0000, 1'b0, SHP_LGE, 24'd0);
    add_tick(32'h0001_0000);
    add_seg(UPD_GOAL | UPD_CURVE | UPD_DUR, 0, 1'b0, 32'h1234_0000, 1'b0, SHP_SPARE, 24'd2);
    add_tick(32'h0001_0000);
    add_seg(UPD_DUR, 0, 1'b0, 0, 1'b0, SHP_HOLD, DUR_MAX);
    add_tick(32'h0001_0000); add_tick(32'h0001_0000);
    // random: mostly goal segments followed by enough ticks, with noise
    k = 0;
    while (k < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        add_seg((($urandom_range(0, 9) < 8) ? UPD_GOAL : 5'h0) | 5'($urandom),
                pick_level(), 1'($urandom), pick_level(), 1'($urandom), 3'($urandom),
                ($urandom_range(0, 40) == 0) ? 24'($urandom)
                                             : 24'($urandom_range(0, 12)));
        ticks = $urandom_range(0, 10);
        k += 1 + ticks;
        repeat (ticks) add_tick(pick_mult());
      end else begin
        if ($urandom_range(0, 1)) add_tick(pick_mult());
        else add_seg(5'($urandom), $urandom, 1'($urandom), $urandom, 1'($urandom),
                     3'($urandom), 24'($urandom));
        k++;
      end
    end
    n_total = req_queue.size();
  end

  // reset and state init
  initial begin
    lvl_start = 0; lvl_goal = 0; pos = 0; end_pt = 0; env_curve = SHP_HOLD;
    goal_open = 1'b0; goal_rat = 1'b0; start_rat = 1'b0; span_set = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst = 1'b0;
  end

  // idling phases follow progress through the requests
  always @(negedge clk) begin
    if (n_accepted > 2 * n_total / 3) begin
      send_idle = 0; recv_idle = 0;
    end else if (n_accepted > n_total / 3) begin
      send_idle = 66; recv_idle = 9;
    end
  end

  // driver: hold a request until taken, then maybe idle or send the next
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || n_accepted == n_issued)) begin
      if (req_queue.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        ramp_req_t r;
        r = req_queue.pop_front();
        req_inflight.push_back(r);
        s_tdata <= {6'd0, r.dur, r.shape, r.gratio, r.gval, r.sratio, r.sval, r.mask, r.mult};
        s_tuser <= r.mode;
        s_tvalid <= 1'b1;
        n_issued++;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= !rst && ($urandom_range(0, 99) >= recv_idle);
  end

  // monitor: predict on accepted requests, check accepted samples
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      predict_ramp(req_inflight.pop_front());
      n_accepted++;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (sample_queue.size() == 0) begin
        $display("%0t: unexpected sample %h", $time, m_tdata);
        n_errors++;
      end else begin
        ramp_sample_t e;
        e = sample_queue.pop_front();
        n_samples++;
        if (m_tdata[31:0] !== e.sample) begin
          $display("%0t: sample_out expected %h actual %h", $time, e.sample, m_tdata[31:0]);
          n_errors++;
        end
        if (m_tdata[32] !== e.pending) begin
          $display("%0t: goal_pending expected %b actual %b", $time, e.pending, m_tdata[32]);
          n_errors++;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (!rst);
    wait (n_total > 0 && n_accepted == n_total && sample_queue.size() == 0);
    repeat (200) @(posedge clk);
    if (sample_queue.size() != 0) n_errors++;
    $display("covered %0d ticks and %0d segment requests, %0d samples checked",
             n_ticks, n_segs, n_samples);
    if (n_errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout with %0d of %0d requests accepted", n_accepted, n_total);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
design/srg_pkg.sv
design/srg_mul.sv
design/srg_div.sv
design/shaped_ramp_envelope_generator.sv
bench/shaped_ramp_envelope_generator_test.sv
